[hdl/gpd_pkg.sv]
// ----------------------------------------------------------------------------
// GF(2) polynomial divider package
// Shared widths, codes, state encoding and the cell link types.
// ----------------------------------------------------------------------------
`default_nettype none

package gpd_pkg;

   // Fixed widths of the request and response words
   localparam int unsigned WORD_WIDTH         = 64;
   localparam int unsigned REM_WIDTH          = 63;
   localparam int unsigned DATA_WIDTH_DEFAULT = 64;

   // Generator after reset: x^6 + x^4 + x^3 + x + 1
   localparam logic [WORD_WIDTH-1:0] POLY_RESET = 64'h5B;

   typedef enum logic {
      CMD_DIVIDE = 1'b0,
      CMD_ENCODE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_POLY = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOPBIT,
      ST_LOAD,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   // Broadcast control into every cell of the chain
   typedef struct packed {
      logic load;
      logic step;
      logic feedback;
   } cell_ctrl_type;

   // What one cell hands to its upper neighbor
   typedef struct packed {
      logic div;
      logic rem;
      logic quo;
   } cell_link_type;

endpackage : gpd_pkg

`default_nettype wire

[hdl/gf2_poly_divider_crc_encoder_core.sv]
// ----------------------------------------------------------------------------
// GF(2) polynomial divider and CRC encoder
// Divides a request word modulo 2 by the generator, or builds a CRC codeword.
// ----------------------------------------------------------------------------
// Each request carries a command and an operand. Divide gives the modulo-2
// quotient and remainder of the operand by the generator polynomial held in
// the CSR; encode shifts the message up by the generator degree, divides, and
// returns the FCS and the codeword. A zero generator, or an encode message
// that no longer fits DATA_WIDTH bits once shifted, returns an error status
// with all data fields zero. A request passes a setup step that finds the
// generator's leading term, a load step that aligns the dividend, a shift
// phase in which the chain of cells takes in one dividend bit per clock, and
// a finish step that fills the response register once the previous response
// has been taken. Errors skip the shift phase. One request is in work at a
// time; the next is taken the cycle after the result is registered, even
// while the previous response still waits. Write the CSR only while the
// block is idle.
`default_nettype none

module gf2_poly_divider_crc_encoder_core #(
   parameter int unsigned DATA_WIDTH = gpd_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [gpd_pkg::WORD_WIDTH-1:0] csr_wr_data,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_cmd,
   input  wire logic [gpd_pkg::WORD_WIDTH-1:0] req_operand,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [gpd_pkg::WORD_WIDTH-1:0]      rsp_quotient,
   output logic [gpd_pkg::REM_WIDTH-1:0]       rsp_remainder,
   output logic [gpd_pkg::WORD_WIDTH-1:0]      rsp_codeword,
   output logic                                rsp_remainder_zero,
   output logic [1:0]                          rsp_status
);
   import gpd_pkg::*;

   localparam int unsigned DEG_WIDTH = $clog2(DATA_WIDTH);
   localparam logic [DEG_WIDTH-1:0] LAST_STEP = DEG_WIDTH'(DATA_WIDTH - 1);

   // Keep only the highest set bit
   function automatic logic [DATA_WIDTH-1:0] top_bit_mask(input logic [DATA_WIDTH-1:0] v);
      logic [DATA_WIDTH-1:0] s;
      s = v;
      for (int k = 1; k < DATA_WIDTH; k = k * 2) begin
         s = s | (s >> k);
      end
      return v & ~(s >> 1);
   endfunction

   // Position of the single set bit
   function automatic logic [DEG_WIDTH-1:0] mask_to_index(input logic [DATA_WIDTH-1:0] m);
      logic [DEG_WIDTH-1:0] idx;
      idx = '0;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         if (m[i]) begin
            idx = idx | DEG_WIDTH'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] bit_reverse(input logic [DATA_WIDTH-1:0] v);
      logic [DATA_WIDTH-1:0] r;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         r[i] = v[DATA_WIDTH-1-i];
      end
      return r;
   endfunction

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0]    opnd_ff, opnd_in;
   logic [DATA_WIDTH-1:0]    poly_ff, poly_in;
   logic [DATA_WIDTH-1:0]    topmask_ff, topmask_in;
   logic [DEG_WIDTH-1:0]     deg_ff, deg_in;
   logic [DATA_WIDTH-1:0]    msg_ff, msg_in;
   status_type               status_ff, status_in;
   logic [DEG_WIDTH-1:0]     cnt_ff, cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0]    rsp_quotient_ff, rsp_quotient_in;
   logic [REM_WIDTH-1:0]     rsp_remainder_ff, rsp_remainder_in;
   logic [WORD_WIDTH-1:0]    rsp_codeword_ff, rsp_codeword_in;
   logic                     rsp_zero_ff, rsp_zero_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic                     req_take;
   logic                     rsp_load;
   logic                     overflow;
   logic [DATA_WIDTH-1:0]    dividend;
   logic [DATA_WIDTH-1:0]    rem_w;
   logic [DATA_WIDTH-1:0]    quo_w;
   logic [DATA_WIDTH-1:0]    tap_w;
   logic                     feedback;
   cell_ctrl_type            cell_ctrl;
   cell_link_type            head;
   cell_link_type            link [DATA_WIDTH];

   assign req_take = req_valid && req_ready;
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Align the dividend and check that a shifted message still fits
   assign overflow = |(opnd_ff & bit_reverse(topmask_ff - DATA_WIDTH'(1)));
   assign dividend = (cmd_ff == CMD_ENCODE) ? (opnd_ff << deg_ff) : opnd_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_TOPBIT;
            end
         end
         ST_TOPBIT: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (topmask_ff == '0 || (cmd_ff == CMD_ENCODE && overflow)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Controls by state
   always_comb begin
      req_ready      = 1'b0;
      cell_ctrl      = '{load: 1'b0, step: 1'b0, feedback: feedback};
      unique case (state_ff)
         ST_IDLE:   req_ready      = 1'b1;
         ST_LOAD:   cell_ctrl.load = 1'b1;
         ST_SHIFT:  cell_ctrl.step = 1'b1;
         default:   req_ready      = 1'b0;
      endcase
   end

   // Request capture, setup and step count
   always_comb begin
      cmd_in     = cmd_ff;
      opnd_in    = opnd_ff;
      topmask_in = topmask_ff;
      deg_in     = deg_ff;
      msg_in     = msg_ff;
      status_in  = status_ff;
      cnt_in     = cnt_ff;
      if (req_take) begin
         cmd_in  = cmd_type'(req_cmd);
         opnd_in = req_operand[DATA_WIDTH-1:0];
      end
      if (state_ff == ST_TOPBIT) begin
         topmask_in = top_bit_mask(poly_ff);
         deg_in     = mask_to_index(top_bit_mask(poly_ff));
      end
      if (state_ff == ST_LOAD) begin
         msg_in = dividend;
         cnt_in = '0;
         priority if (topmask_ff == '0) begin
            status_in = STATUS_ZERO_POLY;
         end else if (cmd_ff == CMD_ENCODE && overflow) begin
            status_in = STATUS_OVERFLOW;
         end else begin
            status_in = STATUS_OK;
         end
      end
      if (state_ff == ST_SHIFT) begin
         cnt_in = cnt_ff + DEG_WIDTH'(1);
      end
   end

   // Hold the generator; a CSR write replaces it
   always_comb begin
      poly_in = poly_ff;
      if (csr_wr_en) begin
         poly_in = csr_wr_data[DATA_WIDTH-1:0];
      end
   end

   // Chain of cells: the dividend's top bit enters the remainder at cell 0
   assign head = '{div: 1'b0, rem: link[DATA_WIDTH-1].div, quo: feedback};

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      cell_link_type prev_link;
      if (i == 0) begin : g_head
         assign prev_link = head;
      end else begin : g_body
         assign prev_link = link[i-1];
      end
      gpd_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .load_bit (dividend[i]),
         .poly_bit (poly_ff[i]),
         .top_bit  (topmask_ff[i]),
         .prev     (prev_link),
         .own      (link[i]),
         .tap      (tap_w[i])
      );
      assign rem_w[i] = link[i].rem;
      assign quo_w[i] = link[i].quo;
   end

   // Subtract whenever the bit under the leading term is set
   assign feedback = |tap_w;

   // Response register: load from the finished division, drop when taken
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_quotient_in  = rsp_quotient_ff;
      rsp_remainder_in = rsp_remainder_ff;
      rsp_codeword_in  = rsp_codeword_ff;
      rsp_zero_in      = rsp_zero_ff;
      rsp_status_in    = rsp_status_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         if (status_ff == STATUS_OK) begin
            rsp_quotient_in  = WORD_WIDTH'(quo_w);
            rsp_remainder_in = REM_WIDTH'(WORD_WIDTH'(rem_w));
            rsp_codeword_in  = (cmd_ff == CMD_ENCODE) ? WORD_WIDTH'(msg_ff ^ rem_w)
                                                      : '0;
            rsp_zero_in      = (rem_w == '0);
         end else begin
            rsp_quotient_in  = '0;
            rsp_remainder_in = '0;
            rsp_codeword_in  = '0;
            rsp_zero_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         poly_ff      <= POLY_RESET[DATA_WIDTH-1:0];
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         poly_ff      <= poly_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff           <= cmd_in;
      opnd_ff          <= opnd_in;
      topmask_ff       <= topmask_in;
      deg_ff           <= deg_in;
      msg_ff           <= msg_in;
      status_ff        <= status_in;
      cnt_ff           <= cnt_in;
      rsp_quotient_ff  <= rsp_quotient_in;
      rsp_remainder_ff <= rsp_remainder_in;
      rsp_codeword_ff  <= rsp_codeword_in;
      rsp_zero_ff      <= rsp_zero_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quotient       = rsp_quotient_ff;
   assign rsp_remainder      = rsp_remainder_ff;
   assign rsp_codeword       = rsp_codeword_ff;
   assign rsp_remainder_zero = rsp_zero_ff;
   assign rsp_status         = rsp_status_ff;

`ifndef SYNTH
   ap_take_to_setup: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_TOPBIT)
      else $error("accepted request did not start setup");

   ap_shift_runs: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT && cnt_ff != LAST_STEP |=> state_ff == ST_SHIFT)
      else $error("division left the shift phase early");

   ap_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish state");

   ap_zero_flag_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_remainder_zero |-> rsp_status == STATUS_OK)
      else $error("remainder flag set on an error response");

   ap_error_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_quotient == '0 && rsp_codeword == '0)
      else $error("error response carries data");
`endif

endmodule : gf2_poly_divider_crc_encoder_core

`default_nettype wire

[hdl/gpd_cell.sv]
// ----------------------------------------------------------------------------
// GF(2) divider cell
// One bit position of the dividend shifter, remainder and quotient shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module gpd_cell (
   input  wire logic                   clock,
   input  wire gpd_pkg::cell_ctrl_type ctrl,
   input  wire logic                   load_bit,
   input  wire logic                   poly_bit,
   input  wire logic                   top_bit,
   input  wire gpd_pkg::cell_link_type prev,
   output gpd_pkg::cell_link_type      own,
   output logic                        tap
);
   import gpd_pkg::*;

   logic div_ff, div_in;
   logic rem_ff, rem_in;
   logic quo_ff, quo_in;

   // Load a new dividend bit, or shift up one place and subtract the generator on feedback
   always_comb begin
      div_in = div_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (ctrl.load) begin
         div_in = load_bit;
         rem_in = 1'b0;
         quo_in = 1'b0;
      end else if (ctrl.step) begin
         div_in = prev.div;
         rem_in = prev.rem ^ (ctrl.feedback & poly_bit);
         quo_in = prev.quo;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // Offer the shifted bit if this place holds the generator's leading term
   assign tap = prev.rem & top_bit;

   assign own = '{div: div_ff, rem: rem_ff, quo: quo_ff};

endmodule : gpd_cell

`default_nettype wire
